### hdl/rsp_pkg.sv
`timescale 1ns / 1ps

package rsp_pkg;

  // Protocol characters
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharColon  = 8'h3A;

  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] MaxPayloadReset = 16'd1024;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_ACK     = 3'd1,
    KIND_NAK     = 3'd2,
    KIND_RESTART = 3'd3,
    KIND_DROP    = 3'd4
  } kind_e;

  // Receive phases, one-hot
  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_PAYLOAD = 4'b0010,
    PH_SUM_HI  = 4'b0100,
    PH_SUM_LO  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data_byte;
    logic [CountW-1:0] payload_length;
    logic              seq_present;
    logic [15:0]       seq_id;
  } result_t;

  // ASCII hex digit to nibble; anything else reads as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

### hdl/rsp_if.sv
`timescale 1ns / 1ps

// Received byte channel
interface rsp_rx_if;
  logic              valid;
  logic              ready;
  rsp_pkg::rx_item_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// Result channel
interface rsp_res_if;
  logic             valid;
  logic             ready;
  rsp_pkg::result_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

### hdl/rsp_parser.sv
`timescale 1ns / 1ps

module rsp_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [7:0]                    byte_i,
  input  logic [rsp_pkg::CountW-1:0]    max_payload_i,
  output logic                          res_valid_o,
  output rsp_pkg::result_t              res_o
);
  import rsp_pkg::*;

  phase_e            phase_q, phase_d;
  logic [7:0]        sum_q, sum_d;
  logic [CountW-1:0] count_q, count_d;
  logic [3:0]        sent_hi_q, sent_hi_d;
  logic [15:0]       first_q, first_d;
  logic              colon_q, colon_d;

  logic [CountW-1:0] count_inc;
  logic [7:0]        sent_sum;
  logic              seq_ok;

  assign count_inc = count_q + CountW'(1);
  assign sent_sum  = {sent_hi_q, hex_value(byte_i)};
  assign seq_ok    = (count_q >= CountW'(3)) && colon_q;

  // Next state and result for the byte in the input register
  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    count_d     = count_q;
    sent_hi_d   = sent_hi_q;
    first_d     = first_q;
    colon_d     = colon_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_DATA;

    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == CharDollar) begin
          sum_d     = '0;
          count_d   = '0;
          sent_hi_d = '0;
          first_d   = '0;
          colon_d   = 1'b0;
          phase_d   = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (byte_i == CharDollar) begin
          sum_d       = '0;
          count_d     = '0;
          sent_hi_d   = '0;
          first_d     = '0;
          colon_d     = 1'b0;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_RESTART;
        end else if (byte_i == CharHash) begin
          phase_d = PH_SUM_HI;
        end else if (count_inc >= max_payload_i) begin
          // overflow: drop the packet and resume hunting
          phase_d     = PH_HUNT;
          sum_d       = '0;
          count_d     = '0;
          sent_hi_d   = '0;
          first_d     = '0;
          colon_d     = 1'b0;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_DROP;
        end else begin
          sum_d   = sum_q + byte_i;
          count_d = count_inc;
          if (count_q == CountW'(0)) begin
            first_d = {byte_i, 8'h00};
          end else if (count_q == CountW'(1)) begin
            first_d = {first_q[15:8], byte_i};
          end else if (count_q == CountW'(2)) begin
            colon_d = (byte_i == CharColon);
          end
          res_valid_o     = 1'b1;
          res_o.kind      = KIND_DATA;
          res_o.data_byte = byte_i;
        end
      end
      PH_SUM_HI: begin
        sent_hi_d = hex_value(byte_i);
        phase_d   = PH_SUM_LO;
      end
      PH_SUM_LO: begin
        phase_d     = PH_HUNT;
        res_valid_o = 1'b1;
        if (sent_sum != sum_q) begin
          res_o.kind = KIND_NAK;
        end else begin
          res_o.kind           = KIND_ACK;
          res_o.payload_length = count_q;
          res_o.seq_present    = seq_ok;
          res_o.seq_id         = seq_ok ? first_q : 16'h0000;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  // Packet state, updated once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      sum_q     <= '0;
      count_q   <= '0;
      sent_hi_q <= '0;
      first_q   <= '0;
      colon_q   <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      sent_hi_q <= sent_hi_d;
      first_q   <= first_d;
      colon_q   <= colon_d;
    end
  end

endmodule

### hdl/rsp_packet_receiver_top.sv
`timescale 1ns / 1ps

// Receive side of the remote serial debug protocol. One received byte per
// transaction on rx_i; each byte yields at most one result on rsp_o (payload
// byte, ack with length and optional sequence id, nak, restart, or overflow
// drop). A byte can be taken every clock cycle while rsp_o is not stalled: the
// rate is one byte per cycle, set by the parse step that sits between the input
// register and the result register; a byte's result is loaded into the result
// register when the parse step runs and is then presented on rsp_o. max_payload
// is written through cfg_we_i/cfg_wdata_i; the user must write it only while the
// block is idle, the block itself does not enforce this; it resets to 1024.
module rsp_packet_receiver_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rsp_pkg::CountW-1:0] cfg_wdata_i,
  rsp_rx_if.sink                     rx_i,
  rsp_res_if.source                  rsp_o
);
  import rsp_pkg::*;

  logic [CountW-1:0] max_payload_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  result_t           out_q;

  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  // Handshake: parse when the result register can take a new entry
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign step       = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.payload.rx_byte;
    end
  end

  rsp_parser u_parser (
    .clk_i,
    .rst_ni,
    .step_i        (step),
    .byte_i        (in_byte_q),
    .max_payload_i (max_payload_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import rsp_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int MaxShown   = 50;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  rsp_rx_if  rx_if ();
  rsp_res_if res_if ();

  rsp_packet_receiver_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_i       (rx_if),
    .rsp_o      (res_if)
  );

  // Byte stream waiting to go out, and results the receiver should produce
  logic [7:0] rx_bytes_q[$];
  result_t    pending_results_q[$];

  int n_queued   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_errors   = 0;
  int n_limits   = 0;
  int kind_seen[5];
  int cyc        = 0;

  // Sender and receiver idling controls
  int gap_max    = 0;
  int gap_left   = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int hold_left  = 0;
  int holds_done = 0;
  int last_hold  = -100000;

  // Shadow of the receive state
  phase_e            sh_phase;
  logic [7:0]        sh_sum;
  logic [CountW-1:0] sh_count;
  logic [3:0]        sh_sum_hi;
  logic [15:0]       sh_first_two;
  logic              sh_colon;
  logic [CountW-1:0] limit_now;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still expected", cyc,
               pending_results_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) return c[3:0];
    if (lc >= 8'h61 && lc <= 8'h66) return 4'(lc - 8'h57);
    return 4'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic clear_packet();
    sh_sum       = '0;
    sh_count     = '0;
    sh_sum_hi    = '0;
    sh_first_two = '0;
    sh_colon     = 1'b0;
  endtask

  // Advance the shadow state by one byte and queue the result it causes
  task automatic parse_rx_byte(input logic [7:0] b);
    result_t r;
    bit      emit;
    logic [7:0] sent;
    r    = '0;
    emit = 1'b0;
    case (sh_phase)
      PH_HUNT: begin
        if (b == CharDollar) begin
          clear_packet();
          sh_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (b == CharDollar) begin
          clear_packet();
          r.kind = KIND_RESTART;
          emit   = 1'b1;
        end else if (b == CharHash) begin
          sh_phase = PH_SUM_HI;
        end else begin
          sh_sum = sh_sum + b;
          if (sh_count == 0) sh_first_two[15:8] = b;
          else if (sh_count == 1) sh_first_two[7:0] = b;
          else if (sh_count == 2) sh_colon = (b == CharColon);
          sh_count = sh_count + CountW'(1);
          emit = 1'b1;
          if (sh_count >= limit_now) begin
            sh_phase = PH_HUNT;
            clear_packet();
            r.kind = KIND_DROP;
          end else begin
            r.kind      = KIND_DATA;
            r.data_byte = b;
          end
        end
      end
      PH_SUM_HI: begin
        sh_sum_hi = nibble_of(b);
        sh_phase  = PH_SUM_LO;
      end
      default: begin
        sent     = {sh_sum_hi, nibble_of(b)};
        sh_phase = PH_HUNT;
        emit     = 1'b1;
        if (sent != sh_sum) begin
          r.kind = KIND_NAK;
        end else begin
          r.kind           = KIND_ACK;
          r.payload_length = sh_count;
          r.seq_present    = (sh_count >= 3) && sh_colon;
          r.seq_id         = r.seq_present ? sh_first_two : 16'd0;
        end
      end
    endcase
    if (emit) pending_results_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_errors < MaxShown)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    n_errors++;
  endtask

  // Byte driver: bursts of random length, separated by random gaps unless gap_max is zero
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        parse_rx_byte(rx_if.payload.rx_byte);
        n_accepted++;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          rx_if.valid <= 1'b0;
        end else if (rx_bytes_q.size() > 0) begin
          rx_if.valid <= 1'b1;
          rx_if.payload.rx_byte <= rx_bytes_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
          end
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: periodically re-chosen random stall pattern, plus long holds
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (cyc % 250 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (holds_done < 3 && rx_bytes_q.size() > 24 && cyc - last_hold > 600) begin
        // long hold while the sender keeps offering bytes
        hold_left = 90;
        holds_done++;
        last_hold = cyc;
        res_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= (cyc[2:0] != 3'd5) && (cyc[2:0] != 3'd6);
        endcase
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (pending_results_q.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(got.kind), 32'hFFFF_FFFF);
      end else begin
        want = pending_results_q.pop_front();
        n_results++;
        if (int'(want.kind) < 5) kind_seen[int'(want.kind)]++;
        if (got.kind != want.kind)
          report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.data_byte != want.data_byte)
          report_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
        if (got.payload_length != want.payload_length)
          report_mismatch("payload_length", 32'(got.payload_length),
                          32'(want.payload_length));
        if (got.seq_present != want.seq_present)
          report_mismatch("seq_present", 32'(got.seq_present), 32'(want.seq_present));
        if (got.seq_id != want.seq_id)
          report_mismatch("seq_id", 32'(got.seq_id), 32'(want.seq_id));
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    n_queued++;
  endtask

  // Whole frame with a checksum; bad_high replaces the high digit with a non-hex char
  task automatic push_frame(input string s, input bit upper, input bit bad_high);
    logic [7:0] sum;
    sum = '0;
    push_byte(CharDollar);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
      sum = sum + s[i];
    end
    push_byte(CharHash);
    push_byte(bad_high ? 8'h7A : hex_char(sum[7:4], upper));
    push_byte(hex_char(sum[3:0], upper));
  endtask

  // Mostly well-formed packets with random content, some broken ones
  task automatic add_random_packet();
    int         len;
    int         style;
    int         pick;
    bit         upper;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] wrong;
    style = $urandom_range(0, 99);
    upper = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) begin
      b = 8'($urandom_range(0, 255));
      push_byte(b == CharDollar ? 8'hA4 : b);
    end
    push_byte(CharDollar);
    pick = $urandom_range(0, 19);
    if (pick < 16) len = $urandom_range(0, 10);
    else if (pick < 19) len = $urandom_range(11, 40);
    else len = $urandom_range(41, 120);
    sum = '0;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CharDollar || b == CharHash) b = b ^ 8'h80;
      if (i == 2 && $urandom_range(0, 2) == 0) b = CharColon;
      if (style < 4 && i == len / 2) begin
        // restart in the middle of the payload
        push_byte(CharDollar);
        sum = '0;
      end
      push_byte(b);
      sum = sum + b;
    end
    if (style >= 96) return;  // left open, the next start char restarts it
    push_byte(CharHash);
    if (style < 78) begin
      push_byte(hex_char(sum[7:4], upper));
      push_byte(hex_char(sum[3:0], upper));
    end else if (style < 90) begin
      wrong = sum ^ 8'($urandom_range(1, 255));
      push_byte(hex_char(wrong[7:4], upper));
      push_byte(hex_char(wrong[3:0], upper));
    end else begin
      push_byte(8'($urandom_range(0, 255)));
      push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Wait for the stream to drain and all results to arrive
  task automatic wait_idle();
    do @(negedge clk_i);
    while (n_accepted != n_queued || pending_results_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [CountW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    limit_now = v;
    n_limits++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    int               start;
    logic [CountW-1:0] lim;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    rx_if.valid         = 1'b0;
    rx_if.payload       = '0;
    res_if.ready        = 1'b0;
    limit_now           = MaxPayloadReset;
    sh_phase            = PH_HUNT;
    clear_packet();
    foreach (kind_seen[k]) kind_seen[k] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: noise while hunting, ack with sequence id, restart,
    // empty packet, non-hex digit and upper-case digits giving a nak
    gap_max = 3;
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CharHash);
    push_byte(CharColon);
    push_frame("12:x", 1'b0, 1'b0);
    push_byte(CharDollar);
    push_byte(8'h61);
    push_byte(8'h62);
    push_frame("", 1'b0, 1'b0);
    push_frame("Zq", 1'b1, 1'b1);
    wait_idle();

    // Random phases, one limit setting each
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: lim = 16'd1;
        1: lim = 16'd0;
        2: lim = 16'hFFFF;
        3: lim = 16'd3;
        4: lim = CountW'($urandom_range(2, 12));
        5: lim = MaxPayloadReset;
        6: lim = CountW'($urandom_range(13, 200));
        default: lim = CountW'($urandom_range(1, 65535));
      endcase
      write_limit(lim);
      gap_max = (p % 3 == 1) ? 0 : $urandom_range(2, 8);
      start = n_queued;
      // continue the packet left open before the limit was lowered
      if (p == 3) push_byte(8'h41);
      while (n_queued - start < 128) add_random_packet();
      if (p == 2) begin
        push_byte(CharDollar);
        for (int i = 0; i < 8; i++) push_byte(8'h30 + 8'(i));
      end
      wait_idle();
    end

    repeat (8) @(negedge clk_i);
    $display("Covered %0d bytes under %0d limit settings, %0d long receiver holds",
             n_accepted, n_limits, holds_done);
    $display("Results: %0d payload, %0d ack, %0d nak, %0d restart, %0d drop",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (n_errors == 0 && pending_results_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, pending_results_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
